### rtl/wbe_pkg.sv
// Shared types and constants for the single-wire LED bit waveform encoder.
package wbe_pkg;

    localparam int COUNT_WIDTH = 12;
    localparam int REG_WIDTH   = 12;
    localparam int CMP_WIDTH   = ((COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH) + 1;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int BIT_COUNT_W = 4;

    localparam logic [REG_WIDTH-1:0]   ZERO_HIGH_RESET = REG_WIDTH'(32);
    localparam logic [REG_WIDTH-1:0]   ONE_HIGH_RESET  = REG_WIDTH'(64);
    localparam logic [REG_WIDTH-1:0]   PERIOD_RESET    = REG_WIDTH'(100);
    localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE   = BIT_COUNT_W'(8);

    typedef enum logic [1:0] {
        REG_ZERO_HIGH = 2'd0,
        REG_ONE_HIGH  = 2'd1,
        REG_PERIOD    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [REG_WIDTH-1:0] zero_high_ticks;
        logic [REG_WIDTH-1:0] one_high_ticks;
        logic [REG_WIDTH-1:0] bit_period_ticks;
    } t_cfg;

    typedef struct packed {
        logic underrun;
        logic busy_res;
        logic byte_taken;
        logic line_level;
    } t_result;

endpackage

### rtl/wbe_cfg.sv
// APB register file holding the bit timing settings.
module wbe_cfg
    import wbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_ZERO_HIGH: n_cfg.zero_high_ticks  = pwdata[REG_WIDTH-1:0];
                REG_ONE_HIGH:  n_cfg.one_high_ticks   = pwdata[REG_WIDTH-1:0];
                REG_PERIOD:    n_cfg.bit_period_ticks = pwdata[REG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ZERO_HIGH: prdata = DATA_WIDTH'(r_cfg.zero_high_ticks);
            REG_ONE_HIGH:  prdata = DATA_WIDTH'(r_cfg.one_high_ticks);
            REG_PERIOD:    prdata = DATA_WIDTH'(r_cfg.bit_period_ticks);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high_ticks  <= ZERO_HIGH_RESET;
            r_cfg.one_high_ticks   <= ONE_HIGH_RESET;
            r_cfg.bit_period_ticks <= PERIOD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/wbe_core.sv
// Bit timer, shift register and holding register; one tick per accepted item.
module wbe_core
    import wbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic       i_byte_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_result    o_result
);

    logic [7:0]             r_shift, n_shift;
    logic [BIT_COUNT_W-1:0] r_bits,  n_bits;
    logic [COUNT_WIDTH-1:0] r_tick,  n_tick;
    logic [REG_WIDTH-1:0]   r_high,  n_high;
    logic [7:0]             r_hold,  n_hold;
    logic                   r_hfull, n_hfull;
    logic                   r_hlast, n_hlast;
    logic                   r_slast, n_slast;
    logic                   r_active, n_active;

    logic                   w_load;
    logic                   w_sending;
    logic                   w_end;
    logic [BIT_COUNT_W-1:0] w_bits_dec;
    logic [7:0]             w_shift_nx;
    logic [CMP_WIDTH-1:0]   w_tick_x;
    logic [CMP_WIDTH-1:0]   w_high_x;
    logic [CMP_WIDTH-1:0]   w_per_x;

    always_comb begin
        w_load = (!r_active || (r_bits == '0)) && r_hfull;

        n_shift  = w_load ? r_hold : r_shift;
        n_bits   = w_load ? BITS_PER_BYTE : r_bits;
        n_tick   = w_load ? '0 : r_tick;
        n_high   = r_high;
        if (w_load) begin
            n_high = r_hold[7] ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
        end
        n_slast  = w_load ? r_hlast : r_slast;
        n_hfull  = w_load ? 1'b0 : r_hfull;
        n_hlast  = w_load ? 1'b0 : r_hlast;
        n_hold   = r_hold;
        n_active = w_load || r_active;

        w_sending  = n_active && (n_bits != '0);
        w_tick_x   = CMP_WIDTH'(n_tick);
        w_high_x   = CMP_WIDTH'(n_high);
        w_per_x    = CMP_WIDTH'(i_cfg.bit_period_ticks);
        w_end      = ((w_tick_x + CMP_WIDTH'(1)) >= w_per_x) || (&n_tick);
        w_bits_dec = n_bits - BIT_COUNT_W'(1);
        w_shift_nx = {n_shift[6:0], 1'b0};

        o_result.busy_res   = n_active;
        o_result.underrun   = n_active && (n_bits == '0);
        o_result.line_level = w_sending && (w_tick_x < w_high_x);

        if (w_sending) begin
            if (w_end) begin
                n_tick  = '0;
                n_shift = w_shift_nx;
                n_bits  = w_bits_dec;
                if (w_bits_dec != '0) begin
                    n_high = w_shift_nx[7] ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
                end else if (n_slast) begin
                    n_active = 1'b0;
                    n_slast  = 1'b0;
                end
            end else begin
                n_tick = n_tick + COUNT_WIDTH'(1);
            end
        end

        o_result.byte_taken = i_byte_valid && !n_hfull;
        if (o_result.byte_taken) begin
            n_hold  = i_data_byte;
            n_hlast = i_last_byte;
            n_hfull = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_bits   <= '0;
            r_tick   <= '0;
            r_high   <= '0;
            r_hold   <= '0;
            r_hfull  <= 1'b0;
            r_hlast  <= 1'b0;
            r_slast  <= 1'b0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_tick   <= n_tick;
            r_high   <= n_high;
            r_hold   <= n_hold;
            r_hfull  <= n_hfull;
            r_hlast  <= n_hlast;
            r_slast  <= n_slast;
            r_active <= n_active;
        end
    end

endmodule

### rtl/wbe_out.sv
// Result register with a one-entry skid stage.
module wbe_out
    import wbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_take
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_out_valid && !i_take) begin
            if (i_push) begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (r_skid_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end else begin
            n_out       = i_result;
            n_out_valid = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### rtl/ws2812_bit_waveform_encoder.sv
// Top level of the single-wire LED strip bit waveform encoder.
// Each input item is one tick of the waveform timer and yields exactly one result item;
// one item is accepted per cycle while s_axis_tready is high; its result is registered.
// While a result waits, a one-entry skid stage takes one more item; after that
// s_axis_tready stays low until m_axis_tready takes the waiting result.
// Input tdata carries data_byte, tuser carries byte_valid and tlast carries last_byte.
// A byte is held in a one-byte buffer and sent MSB first; each bit period lasts
// bit_period_ticks items, with the line high for zero_high_ticks or one_high_ticks.
// Timing registers sit at APB byte addresses 0x0, 0x4 and 0x8 and take effect
// at the next bit (the period length is read live).
module ws2812_bit_waveform_encoder
    import wbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] byte_valid
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata    // [0] line_level [1] byte_taken
                                                  // [2] busy_res [3] underrun, rest 0
);

    t_cfg    w_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_step;

    assign w_step = s_axis_tvalid && s_axis_tready;

    wbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wbe_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_step       (w_step),
        .i_byte_valid (s_axis_tuser),
        .i_data_byte  (s_axis_tdata),
        .i_last_byte  (s_axis_tlast),
        .o_result     (w_core_res)
    );

    wbe_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_step),
        .i_result (w_core_res),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_res),
        .i_take   (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, w_out_res.underrun, w_out_res.busy_res,
                           w_out_res.byte_taken, w_out_res.line_level};

endmodule
